// ===== hw/rtl/ilt_pkg.sv =====
// Shared word types, class encoding and constants for the indent level tracker.
`timescale 1ns / 1ps

package ilt_pkg;

   localparam int unsigned ColWidth = 12;
   localparam int unsigned IndentWidth = 15;
   localparam int unsigned StepWidth = 7;
   localparam logic [StepWidth-1:0] IndentSizeReset = 7'd4;

   localparam logic FuncSeed = 1'b0;
   localparam logic FuncScan = 1'b1;

   localparam logic [1:0] SeenNone = 2'd0;
   localparam logic [1:0] SeenOne = 2'd1;
   localparam logic [1:0] SeenMany = 2'd2;

   typedef struct packed {
      logic                func;
      logic                match_increase;
      logic                match_decrease;
      logic                match_increase_next;
      logic                match_ignore;
      logic                match_zero_indent;
      logic                line_blank;
      logic [ColWidth-1:0] leading_columns;
   } req_word_type;

   typedef struct packed {
      logic                   seeded;
      logic [IndentWidth-1:0] indent;
      logic                   ignored;
   } rsp_word_type;

   typedef struct packed {
      logic zero;
      logic ign;
      logic next;
      logic dec;
      logic inc;
   } class_type;

endpackage

// ===== hw/rtl/ilt_classify.sv =====
// Priority reduction of the raw pattern match bits into a line class.
`timescale 1ns / 1ps

module ilt_classify (
   input  ilt_pkg::req_word_type word,
   output ilt_pkg::class_type    cls
);
   import ilt_pkg::*;

   always_comb begin
      cls = '0;
      priority if (word.match_ignore) begin
         cls.ign = 1'b1;
      end else if (word.match_zero_indent) begin
         cls.zero = 1'b1;
      end else begin
         cls.inc = word.match_increase;
         cls.dec = word.match_decrease;
         cls.next = word.match_increase_next && !word.match_increase;
      end
   end

endmodule

// ===== hw/rtl/ilt_track.sv =====
// Level, carry and seeding state with the per-line update and result logic.
`timescale 1ns / 1ps

module ilt_track #(
   parameter int unsigned LEVEL_WIDTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           enable,
   input  ilt_pkg::req_word_type          word,
   input  ilt_pkg::class_type             cls,
   input  logic [ilt_pkg::StepWidth-1:0]  indent_size,
   output ilt_pkg::rsp_word_type          result
);
   import ilt_pkg::*;

   localparam int unsigned SW = (LEVEL_WIDTH + 2 > 17) ? LEVEL_WIDTH + 2 : 17;
   localparam logic signed [SW-1:0] LvlMax =
      {{(SW-LEVEL_WIDTH+1){1'b0}}, {(LEVEL_WIDTH-1){1'b1}}};
   localparam logic signed [SW-1:0] LvlMin = ~LvlMax;
   localparam logic signed [SW-1:0] IndentMax = SW'(32767);

   logic signed [LEVEL_WIDTH-1:0] level_ff, level_in;
   logic signed [LEVEL_WIDTH-1:0] carry_ff, carry_in;
   logic signed [LEVEL_WIDTH-1:0] prev_ff, prev_in;
   logic [1:0]                    seen_ff, seen_in;
   class_type                     first_ff, first_in;

   function automatic logic signed [LEVEL_WIDTH-1:0] sat(input logic signed [SW-1:0] v);
      logic signed [LEVEL_WIDTH-1:0] r;
      if (v > LvlMax) begin
         r = LvlMax[LEVEL_WIDTH-1:0];
      end else if (v < LvlMin) begin
         r = LvlMin[LEVEL_WIDTH-1:0];
      end else begin
         r = v[LEVEL_WIDTH-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [SW-1:0] ext(input logic signed [LEVEL_WIDTH-1:0] v);
      return {{(SW-LEVEL_WIDTH){v[LEVEL_WIDTH-1]}}, v};
   endfunction

   always_comb begin
      logic signed [SW-1:0]          step;
      logic signed [SW-1:0]          cols;
      logic signed [SW-1:0]          r;
      logic signed [LEVEL_WIDTH-1:0] lvl1;
      logic signed [LEVEL_WIDTH-1:0] car1;

      step = {{(SW-StepWidth){1'b0}}, indent_size};
      cols = {{(SW-ColWidth){1'b0}}, word.leading_columns};
      level_in = level_ff;
      carry_in = carry_ff;
      prev_in = prev_ff;
      seen_in = seen_ff;
      first_in = first_ff;
      r = ext(level_ff) + ext(carry_ff);
      lvl1 = level_ff;
      car1 = carry_ff;
      result = '0;
      result.ignored = word.line_blank || cls.ign;

      if (word.func == FuncSeed) begin
         if (!(word.line_blank || cls.ign || cls.zero)) begin
            seen_in = (seen_ff == SeenMany) ? SeenMany : seen_ff + 2'd1;
            if (seen_ff == SeenNone) begin
               level_in = cols[LEVEL_WIDTH-1:0];
               prev_in = cols[LEVEL_WIDTH-1:0];
               first_in = cls;
               carry_in = '0;
               if (cls.inc) begin
                  level_in = sat(cols + step);
               end
               if (cls.next) begin
                  carry_in = step[LEVEL_WIDTH-1:0];
               end
            end else if (cls.next && !(first_ff.inc || first_ff.dec)) begin
               level_in = cols[LEVEL_WIDTH-1:0];
               prev_in = cols[LEVEL_WIDTH-1:0];
               if (first_ff.next && (cols < ext(prev_ff))) begin
                  carry_in = sat(ext(carry_ff) + ext(prev_ff) - cols);
               end
            end else begin
               result.seeded = 1'b1;
            end
         end
      end else begin
         if (cls.zero) begin
            r = '0;
         end else if (!cls.ign) begin
            if (cls.inc || cls.dec) begin
               car1 = '0;
            end
            if (cls.dec && (!cls.inc || level_ff > 0)) begin
               lvl1 = sat(ext(level_ff) - step);
            end
            r = ext(lvl1) + ext(car1);
            level_in = cls.inc ? sat(ext(lvl1) + step) : lvl1;
            carry_in = cls.next ? sat(ext(car1) + step) : '0;
         end
         if (r < 0) begin
            result.indent = '0;
         end else if (r > IndentMax) begin
            result.indent = IndentMax[IndentWidth-1:0];
         end else begin
            result.indent = r[IndentWidth-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
         carry_ff <= '0;
         prev_ff <= '0;
         seen_ff <= SeenNone;
         first_ff <= '0;
      end else if (enable) begin
         level_ff <= level_in;
         carry_ff <= carry_in;
         prev_ff <= prev_in;
         seen_ff <= seen_in;
         first_ff <= first_in;
      end
   end

endmodule

// ===== hw/rtl/indent_level_tracker.sv =====
// Top level: input register, line tracker and result register of the indent level tracker.
//
// One request word carries one text line: a mode bit (seed or scan), five raw
// pattern match bits, a blank flag and the leading column count. Each request
// word produces exactly one response word (seeded, indent, ignored), in order.
// Both channels use valid/ready; a word moves when valid and ready are high.
// The csr port writes the indent size (columns per step) with no handshake;
// write it only while no word is in flight.
// An accepted request word is held in the input register, then the class
// reduction and level update feed the response register. Throughput is one
// word per cycle while the receiver does not stall, set by the single pass
// through that update logic.
// When the receiver stalls, the response register holds and the input
// register fills; req_ready drops only when both are occupied.
// Synchronous reset empties both registers, clears level, carry, seeding
// state and sets the indent size to four.
`timescale 1ns / 1ps

module indent_level_tracker #(
   parameter int unsigned LEVEL_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  ilt_pkg::req_word_type         req_word,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output ilt_pkg::rsp_word_type         rsp_word,
   input  logic                          csr_write_enable,
   input  logic [ilt_pkg::StepWidth-1:0] csr_write_data
);
   import ilt_pkg::*;

   logic                 s1_valid_ff, s1_valid_in;
   req_word_type         s1_word_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_word_type         rsp_word_ff;
   logic [StepWidth-1:0] indent_size_ff;
   logic                 req_accept;
   logic                 s1_advance;
   class_type            cls;
   rsp_word_type         result;

   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_advance;
   assign req_accept = req_valid && req_ready;
   assign s1_valid_in = req_accept || (s1_valid_ff && !s1_advance);
   assign rsp_valid_in = s1_advance || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_word_ff;

   ilt_classify u_classify (
      .word (s1_word_ff),
      .cls  (cls)
   );

   ilt_track #(
      .LEVEL_WIDTH (LEVEL_WIDTH)
   ) u_track (
      .clock       (clock),
      .reset       (reset),
      .enable      (s1_advance),
      .word        (s1_word_ff),
      .cls         (cls),
      .indent_size (indent_size_ff),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         indent_size_ff <= IndentSizeReset;
      end else begin
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            indent_size_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_word_ff <= req_word;
      end
      if (s1_advance) begin
         rsp_word_ff <= result;
      end
   end

`ifndef SYNTHESIS
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> s1_valid_ff)
      else $error("accepted word lost from input register");
   a_seed_scan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_word.seeded && rsp_word.indent != '0))
      else $error("seeded and indent both set");
   a_seed_not_ignored: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.seeded |-> !rsp_word.ignored)
      else $error("seeding reported on ignored line");
`endif

endmodule
